[rtl/closest_point_on_segment_top_macros.svh]
// Assertion macros used by the checker file cps_checker.sv.
`ifndef CLOSEST_POINT_ON_SEGMENT_TOP_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define CPS_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/cps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Widths, types and helpers of the closest point on segment pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int COORD_W = 24;
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DEN_W   = 2 * COORD_W + 2;
    localparam int DOT_W   = 2 * COORD_W + 4;
    localparam int T_W     = FRAC_W + 1;
    localparam int SCL_W   = DIFF_W + T_W + 1;
    localparam int MIN_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    localparam logic [T_W-1:0] T_ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef enum logic [2:0] {
        REG_A_X,
        REG_A_Y,
        REG_A_Z,
        REG_B_X,
        REG_B_Y,
        REG_B_Z,
        REG_MIN_SQR
    } t_reg_idx;

    typedef logic [COORD_W-1:0]         t_coord;
    typedef logic [2:0][COORD_W-1:0]    t_vec3;

    typedef struct packed {
        t_vec3 a;
        t_vec3 b;
    } t_seg;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [DEN_W-1:0]        den;
    } t_sums;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic           degen;
    } t_param;

    // Sign-extended difference x - y.
    function automatic logic signed [DIFF_W-1:0] f_diff(t_coord x, t_coord y);
        return $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
    endfunction

endpackage

[rtl/cps_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_query_if / cps_near_if
// Valid/ready channels for query points and closest point results.
// ----------------------------------------------------------------------------
interface cps_query_if;
    import cps_pkg::*;

    logic   valid;
    logic   ready;
    t_coord query_x;
    t_coord query_y;
    t_coord query_z;

    modport source (output valid, output query_x, output query_y, output query_z,
                    input ready);
    modport sink   (input valid, input query_x, input query_y, input query_z,
                    output ready);
endinterface

interface cps_near_if;
    import cps_pkg::*;

    logic           valid;
    logic           ready;
    t_coord         near_x;
    t_coord         near_y;
    t_coord         near_z;
    logic [T_W-1:0] param_t;
    logic           degenerate;

    modport source (output valid, output near_x, output near_y, output near_z,
                    output param_t, output degenerate, input ready);
    modport sink   (input valid, input near_x, input near_y, input near_z,
                    input param_t, input degenerate, output ready);
endinterface

[rtl/cps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_front
// Three stages: offsets from A, products, then dot and squared length sums.
// ----------------------------------------------------------------------------
module cps_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cps_pkg::t_seg i_seg,
    input  logic          i_valid,
    output logic          o_ready,
    input  cps_pkg::t_vec3 i_query,
    output logic          o_valid,
    input  logic          i_ready,
    output cps_pkg::t_sums o_sums
);
    import cps_pkg::*;

    logic [2:0] r_v;
    logic [2:0] w_en;

    logic signed [DIFF_W-1:0] w_d   [3];
    logic signed [DIFF_W-1:0] r_q   [3];
    logic signed [PROD_W-1:0] r_pd  [3];
    logic signed [PROD_W-1:0] r_sq  [3];
    t_sums                    n_sums;
    t_sums                    r_sums;

    always_comb begin
        w_en[2] = !r_v[2] || i_ready;
        w_en[1] = !r_v[1] || w_en[2];
        w_en[0] = !r_v[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[2];
    assign o_sums  = r_sums;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = f_diff(i_seg.b[i], i_seg.a[i]);
        end
        n_sums.dot = DOT_W'(r_pd[0]) + DOT_W'(r_pd[1]) + DOT_W'(r_pd[2]);
        n_sums.den = DEN_W'($unsigned(r_sq[0])) + DEN_W'($unsigned(r_sq[1]))
                   + DEN_W'($unsigned(r_sq[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (w_en[0]) r_q[i] <= f_diff(i_query[i], i_seg.a[i]);
            if (w_en[1]) begin
                r_pd[i] <= r_q[i] * w_d[i];
                r_sq[i] <= w_d[i] * w_d[i];
            end
        end
        if (w_en[2]) r_sums <= n_sums;
    end

endmodule

[rtl/cps_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_div
// Clamp decision followed by a restoring divider, one quotient bit a stage.
// ----------------------------------------------------------------------------
module cps_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cps_pkg::MIN_W-1:0] i_min_sqr,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  cps_pkg::t_sums            i_sums,
    output logic                      o_valid,
    input  logic                      i_ready,
    output cps_pkg::t_param           o_param
);
    import cps_pkg::*;

    localparam int NS = FRAC_W + 1;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    logic [DEN_W-1:0]  r_rem   [NS];
    logic [DEN_W-1:0]  n_rem   [NS];
    logic [DEN_W-1:0]  r_den   [NS];
    logic [FRAC_W-1:0] r_quo   [NS];
    logic [FRAC_W-1:0] n_quo   [NS];
    logic [NS-1:0]     r_zero;
    logic [NS-1:0]     r_one;
    logic [NS-1:0]     r_degen;

    logic w_degen;
    logic w_zero;
    logic w_one;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];

    always_comb begin
        logic [DEN_W:0] sh;
        w_degen  = i_sums.den <= DEN_W'(i_min_sqr);
        w_zero   = w_degen || (i_sums.dot <= 0);
        w_one    = !w_zero && ($signed({2'b00, i_sums.den}) <= i_sums.dot);
        // only a dot strictly inside (0, den) enters the divider
        n_rem[0] = (w_zero || w_one) ? '0 : DEN_W'(i_sums.dot);
        n_quo[0] = '0;
        for (int k = 1; k < NS; k++) begin
            sh = {r_rem[k-1], 1'b0};
            if (sh >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = DEN_W'(sh - {1'b0, r_den[k-1]});
                n_quo[k] = {r_quo[k-1][FRAC_W-2:0], 1'b1};
            end else begin
                n_rem[k] = sh[DEN_W-1:0];
                n_quo[k] = {r_quo[k-1][FRAC_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0]   <= n_rem[0];
            r_quo[0]   <= n_quo[0];
            r_den[0]   <= i_sums.den;
            r_zero[0]  <= w_zero;
            r_one[0]   <= w_one;
            r_degen[0] <= w_degen;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_en[k]) begin
                r_rem[k]   <= n_rem[k];
                r_quo[k]   <= n_quo[k];
                r_den[k]   <= r_den[k-1];
                r_zero[k]  <= r_zero[k-1];
                r_one[k]   <= r_one[k-1];
                r_degen[k] <= r_degen[k-1];
            end
        end
    end

    always_comb begin
        if (r_one[NS-1]) begin
            o_param.t = T_ONE;
        end else if (r_zero[NS-1]) begin
            o_param.t = '0;
        end else begin
            o_param.t = {1'b0, r_quo[NS-1]};
        end
        o_param.degen = r_degen[NS-1];
    end

endmodule

[rtl/cps_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_back
// Scale B-A by t, then add A; the second stage is the output register.
// ----------------------------------------------------------------------------
module cps_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cps_pkg::t_seg   i_seg,
    input  logic            i_valid,
    output logic            o_ready,
    input  cps_pkg::t_param i_param,
    output logic            o_valid,
    input  logic            i_ready,
    output cps_pkg::t_vec3  o_near,
    output cps_pkg::t_param o_param
);
    import cps_pkg::*;

    logic [1:0] r_v;
    logic [1:0] w_en;

    logic signed [SCL_W-1:0] r_scl [3];
    logic signed [SCL_W-1:0] w_shr [3];
    t_param                  r_p1;
    t_param                  r_p2;
    t_vec3                   n_near;
    t_vec3                   r_near;

    always_comb begin
        w_en[1] = !r_v[1] || i_ready;
        w_en[0] = !r_v[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[1];
    assign o_near  = r_near;
    assign o_param = r_p2;

    // arithmetic shift gives the floor for negative spans
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_shr[i]  = r_scl[i] >>> FRAC_W;
            n_near[i] = COORD_W'(w_shr[i]) + i_seg.a[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_scl[i] <= f_diff(i_seg.b[i], i_seg.a[i]) * $signed({1'b0, i_param.t});
            end
            r_p1 <= i_param;
        end
        if (w_en[1]) begin
            r_near <= n_near;
            r_p2   <= r_p1;
        end
    end

endmodule

[rtl/closest_point_on_segment_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_segment_top
// Closest point on a configured 3D segment, signed fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Program ends A and B and the squared length threshold over the APB
//   port (one register per 4 bytes) while no query is in flight.
//   Send query points on s_query; each transfer yields exactly one result
//   on m_near with the nearest point, the clamped parameter t and the
//   degenerate flag, in input order.
//   From the input transfer to a valid result, a query passes three
//   front stages (offsets, products, sums), 17 divider stages (clamp
//   decision plus one quotient bit per stage) and two back stages.
//   Throughput is one query per cycle while s_query.ready is high; every stage holds its own valid bit.
//   When m_near stalls, stages fill up from the output backwards and
//   s_query.ready drops only once no bubble remains.
//   Synchronous reset empties the pipeline and clears the configuration registers to 0.
// ----------------------------------------------------------------------------
module closest_point_on_segment_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cps_pkg::ADDR_W-1:0] paddr,
    input  logic [cps_pkg::DATA_W-1:0] pwdata,
    output logic [cps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    cps_query_if.sink                  s_query,
    cps_near_if.source                 m_near
);
    import cps_pkg::*;

    t_seg             r_seg;
    logic [MIN_W-1:0] r_min_sqr;
    t_reg_idx         w_idx;
    logic             w_wr;

    t_vec3  w_query;
    logic   w_f_valid;
    logic   w_f_ready;
    t_sums  w_sums;
    logic   w_d_valid;
    logic   w_d_ready;
    t_param w_dparam;
    t_vec3  w_near;
    t_param w_oparam;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg     <= '0;
            r_min_sqr <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_A_X:     r_seg.a[0] <= pwdata[COORD_W-1:0];
                REG_A_Y:     r_seg.a[1] <= pwdata[COORD_W-1:0];
                REG_A_Z:     r_seg.a[2] <= pwdata[COORD_W-1:0];
                REG_B_X:     r_seg.b[0] <= pwdata[COORD_W-1:0];
                REG_B_Y:     r_seg.b[1] <= pwdata[COORD_W-1:0];
                REG_B_Z:     r_seg.b[2] <= pwdata[COORD_W-1:0];
                REG_MIN_SQR: r_min_sqr  <= pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_A_X:     prdata = DATA_W'(r_seg.a[0]);
            REG_A_Y:     prdata = DATA_W'(r_seg.a[1]);
            REG_A_Z:     prdata = DATA_W'(r_seg.a[2]);
            REG_B_X:     prdata = DATA_W'(r_seg.b[0]);
            REG_B_Y:     prdata = DATA_W'(r_seg.b[1]);
            REG_B_Z:     prdata = DATA_W'(r_seg.b[2]);
            REG_MIN_SQR: prdata = DATA_W'(r_min_sqr);
            default:     prdata = '0;
        endcase
    end

    assign w_query[0] = s_query.query_x;
    assign w_query[1] = s_query.query_y;
    assign w_query[2] = s_query.query_z;

    cps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (r_seg),
        .i_valid (s_query.valid),
        .o_ready (s_query.ready),
        .i_query (w_query),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_sums  (w_sums)
    );

    cps_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_min_sqr (r_min_sqr),
        .i_valid   (w_f_valid),
        .o_ready   (w_f_ready),
        .i_sums    (w_sums),
        .o_valid   (w_d_valid),
        .i_ready   (w_d_ready),
        .o_param   (w_dparam)
    );

    cps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (r_seg),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_param (w_dparam),
        .o_valid (m_near.valid),
        .i_ready (m_near.ready),
        .o_near  (w_near),
        .o_param (w_oparam)
    );

    assign m_near.near_x     = w_near[0];
    assign m_near.near_y     = w_near[1];
    assign m_near.near_z     = w_near[2];
    assign m_near.param_t    = w_oparam.t;
    assign m_near.degenerate = w_oparam.degen;

endmodule

[rtl/cps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_top_macros.svh"

module cps_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    i_ready,
    input cps_pkg::t_coord         i_near_x,
    input cps_pkg::t_coord         i_near_y,
    input cps_pkg::t_coord         i_near_z,
    input logic [cps_pkg::T_W-1:0] i_param_t,
    input logic                    i_degenerate
);
    import cps_pkg::*;

    `CPS_ASSERT(a_hold_valid, i_clk, i_rst_n, i_valid && !i_ready |=> i_valid, "result dropped while stalled")
    `CPS_ASSERT(a_hold_data, i_clk, i_rst_n, i_valid && !i_ready |=> $stable(i_near_x) && $stable(i_near_y) && $stable(i_near_z) && $stable(i_param_t), "result changed while stalled")
    `CPS_ASSERT(a_t_range, i_clk, i_rst_n, i_valid |-> i_param_t <= T_ONE, "param_t above one")
    `CPS_ASSERT(a_degen_t, i_clk, i_rst_n, i_valid && i_degenerate |-> i_param_t == '0, "degenerate result with nonzero t")
    `CPS_ASSERT_NR(a_reset, i_clk, !i_rst_n |=> !i_valid, "result valid right after reset")

endmodule

bind closest_point_on_segment_top cps_checker u_cps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (m_near.valid),
    .i_ready      (m_near.ready),
    .i_near_x     (m_near.near_x),
    .i_near_y     (m_near.near_y),
    .i_near_z     (m_near.near_z),
    .i_param_t    (m_near.param_t),
    .i_degenerate (m_near.degenerate)
);
